### rtl/stpswp_pkg.sv
`default_nettype none

package stpswp_pkg;

  localparam int unsigned CountWidth   = 16;
  localparam int unsigned PhaseWidth   = 3;
  localparam int unsigned PatternWidth = 4;

  localparam logic [CountWidth-1:0] SweepDefault = 16'd2048;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_SWEEP  = 2'd1,
    MODE_RETURN = 2'd2
  } mode_e;

  typedef struct packed {
    logic [PatternWidth-1:0] coil_pattern;
    logic                    stepped;
    logic [1:0]              mode;
    logic                    forward;
  } result_t;

  function automatic logic [PatternWidth-1:0] half_step(input logic [PhaseWidth-1:0] phase);
    logic [PatternWidth-1:0] pat;
    begin
      case (phase)
        3'd0: pat = 4'h1;
        3'd1: pat = 4'h3;
        3'd2: pat = 4'h2;
        3'd3: pat = 4'h6;
        3'd4: pat = 4'h4;
        3'd5: pat = 4'hC;
        3'd6: pat = 4'h8;
        3'd7: pat = 4'h9;
        default: pat = 4'h0;
      endcase
      return pat;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/stpswp_core.sv
`default_nettype none

module stpswp_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                advance_i,
  input  wire logic                                armed_i,
  input  wire logic [stpswp_pkg::CountWidth-1:0]   steps_per_sweep_i,
  output stpswp_pkg::result_t                      result_o
);
  import stpswp_pkg::*;

  mode_e                   mode_q, mode_d;
  logic                    dir_q, dir_d;
  logic [PhaseWidth-1:0]   phase_q, phase_d;
  logic [CountWidth-1:0]   count_q, count_d;
  logic [PatternWidth-1:0] pattern_q, pattern_d;
  logic                    stepped;
  logic                    home;
  logic                    below_limit;

  assign below_limit = count_q < steps_per_sweep_i;

  always_comb begin
    mode_d    = mode_q;
    dir_d     = dir_q;
    phase_d   = phase_q;
    count_d   = count_q;
    pattern_d = pattern_q;
    stepped   = 1'b0;
    home      = 1'b0;
    case (mode_q)
      MODE_WAIT: begin
        phase_d = '0;
        count_d = '0;
        dir_d   = 1'b1;
        mode_d  = armed_i ? MODE_SWEEP : MODE_WAIT;
      end
      MODE_SWEEP: begin
        if (below_limit) begin
          count_d   = count_q + 1'b1;
          pattern_d = half_step(phase_q);
          phase_d   = dir_q ? phase_q + 1'b1 : phase_q - 1'b1;
          stepped   = 1'b1;
        end else begin
          count_d = '0;
          dir_d   = ~dir_q;
          phase_d = '0;
        end
        mode_d = armed_i ? MODE_SWEEP : MODE_RETURN;
      end
      MODE_RETURN: begin
        if (dir_q) begin
          if (count_q != '0) begin
            count_d   = count_q - 1'b1;
            pattern_d = half_step(phase_q);
            phase_d   = phase_q - 1'b1;
            stepped   = 1'b1;
          end else begin
            home = 1'b1;
          end
        end else begin
          if (below_limit) begin
            count_d   = count_q + 1'b1;
            pattern_d = half_step(phase_q);
            phase_d   = phase_q - 1'b1;
            stepped   = 1'b1;
          end else begin
            home = 1'b1;
          end
        end
        mode_d = home ? MODE_WAIT : MODE_RETURN;
      end
      default: begin
        mode_d = MODE_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SWEEP;
      dir_q     <= 1'b1;
      phase_q   <= '0;
      count_q   <= '0;
      pattern_q <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      dir_q     <= dir_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      pattern_q <= pattern_d;
    end
  end

  assign result_o.coil_pattern = pattern_d;
  assign result_o.stepped      = stepped;
  assign result_o.mode         = mode_d;
  assign result_o.forward      = dir_d;

endmodule

`default_nettype wire

### rtl/stepper_sweep_sequencer_top.sv
`default_nettype none

// Half-step sequencer for one four-coil stepper. Each input item is one tick
// carrying the arm flag; each tick yields exactly one result item with the
// coil pattern, a stepped flag, the mode after the tick and the sweep
// direction. An item is held in the input register, then the tick is
// evaluated and lands in the output register; one item is taken every
// cycle while the output side keeps up. Write steps_per_sweep only while
// no items are in flight; it resets to 2048.
module stepper_sweep_sequencer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              armed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [stpswp_pkg::PatternWidth-1:0]    coil_pattern_o,
  output logic                                   stepped_o,
  output logic [1:0]                             mode_o,
  output logic                                   forward_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [stpswp_pkg::CountWidth-1:0] steps_per_sweep_i
);
  import stpswp_pkg::*;

  logic                  in_valid_q;
  logic                  armed_q;
  logic                  out_valid_q;
  result_t               result_q;
  result_t               result_d;
  logic [CountWidth-1:0] sps_q;
  logic                  advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q <= SweepDefault;
    end else if (cfg_valid_i) begin
      sps_q <= steps_per_sweep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      armed_q <= armed_i;
    end
  end

  stpswp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .armed_i           (armed_q),
    .steps_per_sweep_i (sps_q),
    .result_o          (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coil_pattern_o = result_q.coil_pattern;
  assign stepped_o      = result_q.stepped;
  assign mode_o         = result_q.mode;
  assign forward_o      = result_q.forward;

endmodule

`default_nettype wire
